// ----- src/bal_pkg.sv -----
package bal_pkg;

  // curve sampling
  localparam int NUM_SAMPLES = 101;
  localparam int DEN         = NUM_SAMPLES - 1;
  localparam int IDX_W       = $clog2(NUM_SAMPLES);
  localparam int IN_W        = 7;

  // fixed-point widths
  localparam int CRD_W  = 16;
  localparam int T_W    = 17;
  localparam int LEN_W  = 32;
  localparam int PRD_W  = LEN_W + IN_W;
  localparam int DIV_W  = 48;
  localparam int DCNT_W = $clog2(DIV_W);
  localparam int ROOT_W = 21;
  localparam int SOP_W  = 2 * ROOT_W;
  localparam int SCNT_W = $clog2(ROOT_W);

  localparam logic [T_W-1:0] T_ONE = T_W'(65536);

  // division by DEN as a multiplication by the rounded-up reciprocal,
  // exact for every dividend below 2**PRD_W
  localparam int RCP_SH = PRD_W + $clog2(DEN);
  localparam int RCP_H  = (PRD_W + 2) / 2;
  localparam int RCP_W  = 2 * RCP_H;
  localparam logic [RCP_W-1:0] RCP_M =
    RCP_W'(((64'd1 << RCP_SH) + 64'(DEN) - 64'd1) / 64'(DEN));
  localparam logic [RCP_H-1:0] RCP_ML = RCP_M[RCP_H-1:0];
  localparam logic [RCP_H-1:0] RCP_MH = RCP_M[RCP_W-1:RCP_H];

  // table parameter steps, t_k = round(k * 65536 / DEN) built incrementally
  localparam int TR_W     = $clog2(DEN) + 1;
  localparam int T_STEP_Q = 65536 / DEN;
  localparam int T_STEP_R = 65536 % DEN;
  localparam int T_INIT_R = DEN / 2;

  // configuration registers
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_P0_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_P0_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_P3_X = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_P3_Y = CFG_IDX_W'(7);

  // divider operand select
  localparam logic [1:0] DIV_TGT  = 2'd0;
  localparam logic [1:0] DIV_FRAC = 2'd1;
  localparam logic [1:0] DIV_TPAR = 2'd2;

  typedef struct packed {
    logic       load;
    logic       tb_init;
    logic       bez_start;
    logic       sq;
    logic       sqrt_start;
    logic       tb_write;
    logic       pt_p0;
    logic       pt_p3;
    logic       pt_bez;
    logic       tgt_mul;
    logic       div_start;
    logic [1:0] div_sel;
    logic       srch_init;
    logic       rd_mid;
    logic       srch_cmp;
    logic       rd_lo;
    logic       lat_lo;
    logic       lat_hi;
    logic       frac_zero;
    logic       frac_set;
    logic       t_set;
    logic       out_load;
  } bal_cmd_t;

  typedef struct packed {
    logic table_valid;
    logic bez_done;
    logic sqrt_done;
    logic div_done;
    logic tb_last;
    logic tbk_zero;
    logic k_zero;
    logic k_end;
    logic srch_done;
    logic seg_zero;
    logic out_free;
  } bal_sts_t;

endpackage

// ----- src/bal_div.sv -----
module bal_div import bal_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [LEN_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quot
);

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]  dq_r;
  logic [LEN_W-1:0]  dvs_r;
  logic [LEN_W-1:0]  rem_r;
  logic [LEN_W:0]    trial;
  logic              qbit;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_r, dq_r[DIV_W-1]};
  assign qbit  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= qbit ? LEN_W'(trial - {1'b0, dvs_r}) : trial[LEN_W-1:0];
      dq_r  <= {dq_r[DIV_W-2:0], qbit};
    end
  end

  assign done = done_r;
  assign quot = dq_r;

endmodule

// ----- src/bal_bez.sv -----
module bal_bez import bal_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [T_W-1:0]        t,
  input  logic [3:0][CRD_W-1:0] cx,
  input  logic [3:0][CRD_W-1:0] cy,
  output logic                  done,
  output logic [CRD_W-1:0]      bx,
  output logic [CRD_W-1:0]      by
);

  localparam int A_W = 51;
  localparam int W_W = 49;
  localparam int P_W = A_W + T_W;
  localparam int S_W = 64;

  logic             busy_r;
  logic             done_r;
  logic [3:0]       cnt_r;
  logic [T_W-1:0]   t_r;
  logic [T_W-1:0]   u;
  logic [33:0]      u2_r;
  logic [33:0]      t2_r;
  logic [W_W-1:0]   w0_r, w1_r, w2_r, w3_r;
  logic [P_W-1:0]   p_r;
  logic [A_W-1:0]   p3;
  logic [S_W-1:0]   accx_r, accy_r;
  logic [A_W-1:0]   ma;
  logic [T_W-1:0]   mb;
  logic [S_W-1:0]   rndx, rndy;
  logic [CRD_W-1:0] bx_r, by_r;

  assign u  = T_ONE - t_r;
  assign p3 = p_r[A_W-1:0] + {p_r[A_W-2:0], 1'b0};

  // operand select for the shared multiplier, one product per step
  always_comb begin
    ma = '0;
    mb = '0;
    case (cnt_r)
      4'd0:  begin ma = A_W'(u);    mb = u;                 end
      4'd1:  begin ma = A_W'(t_r);  mb = t_r;               end
      4'd2:  begin ma = A_W'(u2_r); mb = u;                 end
      4'd3:  begin ma = A_W'(u2_r); mb = t_r;               end
      4'd4:  begin ma = A_W'(t2_r); mb = u;                 end
      4'd5:  begin ma = A_W'(t2_r); mb = t_r;               end
      4'd6:  begin ma = A_W'(w0_r); mb = T_W'(cx[0]);       end
      4'd7:  begin ma = A_W'(w1_r); mb = T_W'(cx[1]);       end
      4'd8:  begin ma = A_W'(w2_r); mb = T_W'(cx[2]);       end
      4'd9:  begin ma = A_W'(w3_r); mb = T_W'(cx[3]);       end
      4'd10: begin ma = A_W'(w0_r); mb = T_W'(cy[0]);       end
      4'd11: begin ma = A_W'(w1_r); mb = T_W'(cy[1]);       end
      4'd12: begin ma = A_W'(w2_r); mb = T_W'(cy[2]);       end
      4'd13: begin ma = A_W'(w3_r); mb = T_W'(cy[3]);       end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // round half up from Q0.48 weights
  assign rndx = accx_r + (S_W'(1) << 47);
  assign rndy = accy_r + (S_W'(1) << 47);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // product of each step is registered and consumed in the following cycle
  always_ff @(posedge clk) begin
    if (start) begin
      t_r <= t;
    end else if (busy_r) begin
      p_r <= ma * mb;
      case (cnt_r)
        4'd1:  u2_r   <= p_r[33:0];
        4'd2:  t2_r   <= p_r[33:0];
        4'd3:  w0_r   <= p_r[W_W-1:0];
        4'd4:  w1_r   <= p3[W_W-1:0];
        4'd5:  w2_r   <= p3[W_W-1:0];
        4'd6:  w3_r   <= p_r[W_W-1:0];
        4'd7:  accx_r <= p_r[S_W-1:0];
        4'd8, 4'd9, 4'd10: accx_r <= accx_r + p_r[S_W-1:0];
        4'd11: accy_r <= p_r[S_W-1:0];
        4'd12, 4'd13, 4'd14: accy_r <= accy_r + p_r[S_W-1:0];
        4'd15: begin
          bx_r <= rndx[S_W-1:48];
          by_r <= rndy[S_W-1:48];
        end
        default: ;
      endcase
    end
  end

  assign done = done_r;
  assign bx   = bx_r;
  assign by   = by_r;

endmodule

// ----- src/bal_dp.sv -----
module bal_dp import bal_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bal_cmd_t             cmd,
  output bal_sts_t             sts,
  input  logic [IN_W-1:0]      sample_index,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CRD_W-1:0]     cfg_data,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output logic [2*CRD_W-1:0]   out_tdata
);

  // configuration and table state
  logic [NUM_REGS-1:0][CRD_W-1:0] p_r;
  logic                           tvalid_r;
  logic [LEN_W-1:0]               arc_mem [NUM_SAMPLES];
  logic [LEN_W-1:0]               rdata_r;
  logic [IDX_W-1:0]               raddr;
  logic                           rd_en;

  // table build
  logic [IDX_W-1:0]  tbk_r;
  logic [T_W-1:0]    t_r;
  logic [TR_W-1:0]   tr_r;
  logic [TR_W:0]     tr_sum;
  logic [CRD_W-1:0]  px_r, py_r;
  logic [CRD_W-1:0]  dx, dy;
  logic [2*CRD_W-1:0] dxx_r, dyy_r;
  logic [LEN_W-1:0]  acc_r;
  logic [LEN_W:0]    acc_sum;
  logic [LEN_W-1:0]  len_r;

  // square root unit
  logic              sbusy_r, sdone_r;
  logic [SCNT_W-1:0] scnt_r;
  logic [SOP_W-1:0]  sop_r;
  logic [ROOT_W+1:0] srem_r;
  logic [ROOT_W+1:0] srem2, strial;
  logic [ROOT_W-1:0] root_r;

  // query
  logic [IN_W-1:0]  k_r;
  logic [PRD_W-1:0] prod_r;
  logic [LEN_W-1:0] target_r;
  logic [IDX_W-1:0] lo_r, hi_r;
  logic [IDX_W:0]   mid_w;
  logic [IDX_W-1:0] mid;
  logic [LEN_W-1:0] alo_r, ahi_r;
  logic [LEN_W-1:0] seg;
  logic [T_W-1:0]   frac_r;
  logic [CRD_W-1:0] ptx_r, pty_r;
  logic             ovalid_r;
  logic [2*CRD_W-1:0] odata_r;

  // shared units
  logic [DIV_W-1:0] div_a;
  logic [LEN_W-1:0] div_b;
  logic             div_go;
  logic             div_done;
  logic [DIV_W-1:0] quot;
  logic [3:0][CRD_W-1:0] cx, cy;
  logic             bez_done;
  logic [CRD_W-1:0] bx, by;

  // constant divider
  logic                     cdiv_go;
  logic [PRD_W-1:0]         cdiv_a;
  logic                     cv1_r, cv2_r, cdone_r;
  logic [PRD_W-1:0]         cdvd_r;
  logic [PRD_W+RCP_H-1:0]   cplo_r, cphi_r;
  logic [PRD_W+RCP_W-1:0]   crcp_sum;
  logic [PRD_W-1:0]         cquot_r;

  // biased control values for the evaluator
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cx[i] = p_r[2*i]     ^ 16'h8000;
      cy[i] = p_r[2*i + 1] ^ 16'h8000;
    end
  end

  bal_bez u_bez (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.bez_start),
    .t     (t_r),
    .cx    (cx),
    .cy    (cy),
    .done  (bez_done),
    .bx    (bx),
    .by    (by)
  );

  // serial divider handles the fraction, the constant divider the rest
  assign div_go  = cmd.div_start && (cmd.div_sel == DIV_FRAC);
  assign cdiv_go = cmd.div_start && (cmd.div_sel != DIV_FRAC);
  assign div_a   = {target_r - alo_r, 16'h0000};
  assign div_b   = seg;

  always_comb begin
    cdiv_a = prod_r;
    case (cmd.div_sel)
      DIV_TGT:  cdiv_a = prod_r;
      DIV_TPAR: begin
        cdiv_a = PRD_W'({lo_r, 16'h0000}) + PRD_W'(frac_r) + PRD_W'(DEN / 2);
      end
      default:  cdiv_a = prod_r;
    endcase
  end

  bal_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (quot)
  );

  // division by DEN: reciprocal product in two halves; dividend, half products and quotient are registered in turn
  assign crcp_sum = {cphi_r, {RCP_H{1'b0}}} + (PRD_W + RCP_W)'(cplo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv1_r   <= 1'b0;
      cv2_r   <= 1'b0;
      cdone_r <= 1'b0;
    end else begin
      cv1_r   <= cdiv_go;
      cv2_r   <= cv1_r;
      cdone_r <= cv2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cdiv_go)
      cdvd_r <= cdiv_a;
    if (cv1_r) begin
      cplo_r <= cdvd_r * RCP_ML;
      cphi_r <= cdvd_r * RCP_MH;
    end
    if (cv2_r)
      cquot_r <= PRD_W'(crcp_sum[PRD_W+RCP_W-1:RCP_SH]);
  end

  // configuration writes drop the table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r      <= '0;
      tvalid_r <= 1'b0;
    end else if (cfg_valid && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
      p_r[cfg_index[2:0]] <= cfg_data;
      tvalid_r            <= 1'b0;
    end else if (cmd.tb_write && tbk_r == IDX_W'(NUM_SAMPLES - 1)) begin
      tvalid_r <= 1'b1;
    end
  end

  // chord lengths
  assign dx      = (bx > px_r) ? bx - px_r : px_r - bx;
  assign dy      = (by > py_r) ? by - py_r : py_r - by;
  assign acc_sum = {1'b0, acc_r} + (LEN_W + 1)'(root_r);
  assign tr_sum  = {1'b0, tr_r} + (TR_W + 1)'(T_STEP_R);

  always_ff @(posedge clk) begin
    if (cmd.tb_init) begin
      tbk_r <= '0;
      t_r   <= '0;
      tr_r  <= TR_W'(T_INIT_R);
      acc_r <= '0;
    end else if (cmd.tb_write) begin
      tbk_r <= tbk_r + 1'b1;
      px_r  <= bx;
      py_r  <= by;
      acc_r <= acc_sum[LEN_W] ? '1 : acc_sum[LEN_W-1:0];
      if (tbk_r == IDX_W'(NUM_SAMPLES - 1))
        len_r <= acc_sum[LEN_W] ? '1 : acc_sum[LEN_W-1:0];
      if (tr_sum >= (TR_W + 1)'(DEN)) begin
        tr_r <= TR_W'(tr_sum - (TR_W + 1)'(DEN));
        t_r  <= t_r + T_W'(T_STEP_Q + 1);
      end else begin
        tr_r <= tr_sum[TR_W-1:0];
        t_r  <= t_r + T_W'(T_STEP_Q);
      end
    end else if (cmd.t_set) begin
      t_r <= (cquot_r > PRD_W'(T_ONE)) ? T_ONE : cquot_r[T_W-1:0];
    end
    if (cmd.sq) begin
      dxx_r <= dx * dx;
      dyy_r <= dy * dy;
    end
  end

  // table memory, one write and one registered read port
  always_comb begin
    raddr = lo_r;
    rd_en = 1'b0;
    if (cmd.rd_mid) begin
      raddr = mid;
      rd_en = 1'b1;
    end else if (cmd.rd_lo) begin
      raddr = lo_r;
      rd_en = 1'b1;
    end else if (cmd.lat_lo) begin
      raddr = lo_r + 1'b1;
      rd_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tb_write)
      arc_mem[tbk_r] <= acc_sum[LEN_W] ? '1 : acc_sum[LEN_W-1:0];
    if (rd_en)
      rdata_r <= arc_mem[raddr];
  end

  // digit-by-digit square root, one result bit per cycle
  assign srem2  = {srem_r[ROOT_W-1:0], sop_r[SOP_W-1 -: 2]};
  assign strial = {root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sbusy_r <= 1'b0;
      sdone_r <= 1'b0;
      scnt_r  <= '0;
    end else begin
      sdone_r <= 1'b0;
      if (cmd.sqrt_start) begin
        sbusy_r <= 1'b1;
        scnt_r  <= '0;
      end else if (sbusy_r) begin
        scnt_r <= scnt_r + 1'b1;
        if (scnt_r == SCNT_W'(ROOT_W - 1)) begin
          sbusy_r <= 1'b0;
          sdone_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tb_init) begin
      root_r <= '0;
    end else if (cmd.sqrt_start) begin
      sop_r  <= SOP_W'({({1'b0, dxx_r} + {1'b0, dyy_r}), 8'h00});
      srem_r <= '0;
      root_r <= '0;
    end else if (sbusy_r) begin
      sop_r <= {sop_r[SOP_W-3:0], 2'b00};
      if (srem2 >= strial) begin
        srem_r <= srem2 - strial;
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        srem_r <= srem2;
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // search and interpolation
  assign mid_w = {1'b0, lo_r} + (({1'b0, hi_r} - {1'b0, lo_r} + 1'b1) >> 1);
  assign mid   = mid_w[IDX_W-1:0];
  assign seg   = ahi_r - alo_r;

  always_ff @(posedge clk) begin
    if (cmd.load)
      k_r <= sample_index;
    if (cmd.tgt_mul)
      prod_r <= k_r * len_r;
    if (cmd.srch_init) begin
      target_r <= cquot_r[LEN_W-1:0];
      lo_r     <= '0;
      hi_r     <= IDX_W'(NUM_SAMPLES - 2);
    end else if (cmd.srch_cmp) begin
      if (rdata_r <= target_r)
        lo_r <= mid;
      else
        hi_r <= mid - 1'b1;
    end
    if (cmd.lat_lo)
      alo_r <= rdata_r;
    if (cmd.lat_hi)
      ahi_r <= rdata_r;
    if (cmd.frac_zero)
      frac_r <= '0;
    else if (cmd.frac_set)
      frac_r <= (quot > DIV_W'(T_ONE)) ? T_ONE : quot[T_W-1:0];
    if (cmd.pt_p0) begin
      ptx_r <= p_r[REG_P0_X[2:0]];
      pty_r <= p_r[REG_P0_Y[2:0]];
    end else if (cmd.pt_p3) begin
      ptx_r <= p_r[REG_P3_X[2:0]];
      pty_r <= p_r[REG_P3_Y[2:0]];
    end else if (cmd.pt_bez) begin
      ptx_r <= bx ^ 16'h8000;
      pty_r <= by ^ 16'h8000;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load)
      odata_r <= {pty_r, ptx_r};
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

  assign sts.table_valid = tvalid_r;
  assign sts.bez_done    = bez_done;
  assign sts.sqrt_done   = sdone_r;
  assign sts.div_done    = div_done | cdone_r;
  assign sts.tb_last     = (tbk_r == IDX_W'(NUM_SAMPLES - 1));
  assign sts.tbk_zero    = (tbk_r == '0);
  assign sts.k_zero      = (k_r == '0);
  assign sts.k_end       = (IDX_W'(k_r) >= IDX_W'(DEN));
  assign sts.srch_done   = (lo_r >= hi_r);
  assign sts.seg_zero    = (seg == '0);
  assign sts.out_free    = !ovalid_r || out_tready;

endmodule

// ----- src/bal_ctrl.sv -----
module bal_ctrl import bal_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  bal_sts_t sts,
  output bal_cmd_t cmd
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_CHK     = 5'd1;
  localparam logic [4:0] S_TB_BEZ  = 5'd2;
  localparam logic [4:0] S_TB_BWT  = 5'd3;
  localparam logic [4:0] S_TB_SQ   = 5'd4;
  localparam logic [4:0] S_TB_SWT  = 5'd5;
  localparam logic [4:0] S_TB_WR   = 5'd6;
  localparam logic [4:0] S_QSEL    = 5'd7;
  localparam logic [4:0] S_TDIV    = 5'd8;
  localparam logic [4:0] S_TDWT    = 5'd9;
  localparam logic [4:0] S_SRCH    = 5'd10;
  localparam logic [4:0] S_SCMP    = 5'd11;
  localparam logic [4:0] S_RLO     = 5'd12;
  localparam logic [4:0] S_RHI     = 5'd13;
  localparam logic [4:0] S_FRAC    = 5'd14;
  localparam logic [4:0] S_FWT     = 5'd15;
  localparam logic [4:0] S_PDIV    = 5'd16;
  localparam logic [4:0] S_PWT     = 5'd17;
  localparam logic [4:0] S_QBEZ    = 5'd18;
  localparam logic [4:0] S_QBWT    = 5'd19;
  localparam logic [4:0] S_OUT     = 5'd20;
  localparam logic [4:0] S_TB_SQWT = 5'd21;

  logic [4:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.div_sel = DIV_TGT;
    case (state_r)
      S_IDLE: if (in_tvalid) begin
        cmd.load  = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (!sts.table_valid) begin
          cmd.tb_init = 1'b1;
          state_nxt   = S_TB_BEZ;
        end else begin
          state_nxt = S_QSEL;
        end
      end
      S_TB_BEZ: begin
        cmd.bez_start = 1'b1;
        state_nxt     = S_TB_BWT;
      end
      S_TB_BWT: if (sts.bez_done) begin
        state_nxt = sts.tbk_zero ? S_TB_WR : S_TB_SQ;
      end
      S_TB_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = S_TB_SWT;
      end
      S_TB_SWT: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = S_TB_SQWT;
      end
      S_TB_SQWT: if (sts.sqrt_done) begin
        state_nxt = S_TB_WR;
      end
      S_TB_WR: begin
        cmd.tb_write = 1'b1;
        state_nxt    = sts.tb_last ? S_QSEL : S_TB_BEZ;
      end
      S_QSEL: begin
        if (sts.k_zero) begin
          cmd.pt_p0 = 1'b1;
          state_nxt = S_OUT;
        end else if (sts.k_end) begin
          cmd.pt_p3 = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.tgt_mul = 1'b1;
          state_nxt   = S_TDIV;
        end
      end
      S_TDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_TGT;
        state_nxt     = S_TDWT;
      end
      S_TDWT: if (sts.div_done) begin
        cmd.srch_init = 1'b1;
        state_nxt     = S_SRCH;
      end
      S_SRCH: begin
        if (sts.srch_done) begin
          cmd.rd_lo = 1'b1;
          state_nxt = S_RLO;
        end else begin
          cmd.rd_mid = 1'b1;
          state_nxt  = S_SCMP;
        end
      end
      S_SCMP: begin
        cmd.srch_cmp = 1'b1;
        state_nxt    = S_SRCH;
      end
      S_RLO: begin
        cmd.lat_lo = 1'b1;
        state_nxt  = S_RHI;
      end
      S_RHI: begin
        cmd.lat_hi = 1'b1;
        state_nxt  = S_FRAC;
      end
      S_FRAC: begin
        if (sts.seg_zero) begin
          cmd.frac_zero = 1'b1;
          state_nxt     = S_PDIV;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_FRAC;
          state_nxt     = S_FWT;
        end
      end
      S_FWT: if (sts.div_done) begin
        cmd.frac_set = 1'b1;
        state_nxt    = S_PDIV;
      end
      S_PDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_TPAR;
        state_nxt     = S_PWT;
      end
      S_PWT: if (sts.div_done) begin
        cmd.t_set = 1'b1;
        state_nxt = S_QBEZ;
      end
      S_QBEZ: begin
        cmd.bez_start = 1'b1;
        state_nxt     = S_QBWT;
      end
      S_QBWT: if (sts.bez_done) begin
        cmd.pt_bez = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: if (sts.out_free) begin
        cmd.out_load = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      state_r <= S_IDLE;
    else
      state_r <= state_nxt;
  end

endmodule

// ----- src/bezier_arc_length_resampler.sv -----
// a query's time is dominated by the serial division for the fraction, the
//   16-step cubic evaluator and the binary search over the table
// end points take a control point with no search; a stale table is first rebuilt
//   from 101 evaluations, all but the first followed by a 21-step square root
// throughput: one item at a time; the next item is taken while a result waits
// reset: synchronous active-low rst_n clears control points and marks table stale
module bezier_arc_length_resampler import bal_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [6:0] sample_index
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,  // [15:0] point_x, [31:16] point_y
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CRD_W-1:0]     cfg_data
);

  bal_cmd_t cmd;
  bal_sts_t sts;

  assign cfg_ready = 1'b1;

  bal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bal_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .sample_index (in_tdata[IN_W-1:0]),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .out_tdata    (out_tdata)
  );

endmodule
